[design/akd_pkg.sv]
// shared constants, types and codes for the analog keypad debouncer
`default_nettype none

package akd_pkg;

  localparam int NUM_KEYS  = 5;
  localparam int MAX_KEYS  = 5;
  localparam int ADC_W     = 10;
  localparam int KEY_W     = 3;
  localparam int TIME_W    = 32;
  localparam int TOL_W     = 8;
  localparam int CNT_W     = 8;
  localparam int IVL_W     = 16;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 16;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [KEY_W-1:0] NO_KEY  = 3'd0;
  localparam logic [KEY_W-1:0] BAD_KEY = 3'd6;

  localparam logic [ADC_W-1:0] NO_KEY_THRESHOLD = 10'd1000;
  localparam logic [CNT_W-1:0] CNT_MAX          = {CNT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE       = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_COUNT  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 4'd7;

  localparam logic [ADC_W-1:0] LEVEL_RESET [MAX_KEYS] = '{
    10'd10, 10'd149, 10'd332, 10'd501, 10'd735
  };
  localparam logic [TOL_W-1:0] TOLERANCE_RESET = 8'd40;
  localparam logic [CNT_W-1:0] DEBOUNCE_RESET  = 8'd3;
  localparam logic [IVL_W-1:0] INTERVAL_RESET  = 16'd10;

  typedef struct packed {
    logic              op;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now_ms;
  } akd_entry_t;

  typedef struct packed {
    logic [CNT_W-1:0] repeat_need;
    logic [IVL_W-1:0] sample_interval_ms;
  } akd_ctl_t;

endpackage

`default_nettype wire

[design/akd_if.sv]
// handshake channels: sample items, result items and register writes
`default_nettype none

interface akd_sample_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [akd_pkg::ADC_W-1:0]  adc_value;
  logic [akd_pkg::TIME_W-1:0] now_ms;

  modport source (output valid, op, adc_value, now_ms, input ready);
  modport sink (input valid, op, adc_value, now_ms, output ready);
endinterface

interface akd_result_if;
  logic                     valid;
  logic                     ready;
  logic [akd_pkg::KEY_W-1:0] key_out;
  logic                     sample_taken;
  logic                     key_pending;

  modport source (output valid, key_out, sample_taken, key_pending, input ready);
  modport sink (input valid, key_out, sample_taken, key_pending, output ready);
endinterface

interface akd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [akd_pkg::CFG_IDX_W-1:0] index;
  logic [akd_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/analog_keypad_debouncer.sv]
// top level of the analog keypad decoder and debouncer
//
//   channel   | dir | carries
//   ----------+-----+-----------------------------------------------
//   sample_i  | in  | op, adc_value, now_ms
//   result_o  | out | key_out, sample_taken, key_pending
//   cfg_i     | in  | index, data (always ready)
//
// one item per cycle sustained while the output is ready; a result is offered
// once its item has passed through the queue and the result register
// the window compares sit in the front, ahead of the queue; the 32-bit interval
// check and the debounce counter sit in the back, ahead of the result register
// a two-entry queue and the result register let a stalled output hold
// without stopping intake until the queue is full
// reset loads the register defaults and clears all debounce state
`default_nettype none

module analog_keypad_debouncer (
  input  wire          clk_i,
  input  wire          rst_ni,
  akd_sample_if.sink   sample_i,
  akd_result_if.source result_o,
  akd_cfg_if.sink      cfg_i
);

  logic                q_full;
  logic                push;
  akd_pkg::akd_entry_t push_entry;
  akd_pkg::akd_ctl_t   ctl;
  logic                q_valid;
  akd_pkg::akd_entry_t head_entry;
  logic                pop;

  akd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_i),
    .cfg_i    (cfg_i),
    .q_full_i (q_full),
    .push_o   (push),
    .entry_o  (push_entry),
    .ctl_o    (ctl)
  );

  akd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (head_entry),
    .pop_i   (pop)
  );

  akd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .entry_i   (head_entry),
    .ctl_i     (ctl),
    .pop_o     (pop),
    .result_o  (result_o)
  );

endmodule

`default_nettype wire

[design/akd_front.sv]
// front end: register file, item intake and key window classification
`default_nettype none

module akd_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  akd_sample_if.sink          sample_i,
  akd_cfg_if.sink             cfg_i,
  input  wire                 q_full_i,
  output logic                push_o,
  output akd_pkg::akd_entry_t entry_o,
  output akd_pkg::akd_ctl_t   ctl_o
);

  logic [akd_pkg::ADC_W-1:0] level_q [akd_pkg::NUM_KEYS];
  logic [akd_pkg::TOL_W-1:0] tol_q;
  logic [akd_pkg::CNT_W-1:0] debounce_q;
  logic [akd_pkg::IVL_W-1:0] interval_q;

  logic [akd_pkg::ADC_W:0]   v_ext;
  logic [akd_pkg::ADC_W:0]   tol_ext;
  logic [akd_pkg::ADC_W:0]   lvl_ext;
  logic                      hit;
  logic [akd_pkg::KEY_W-1:0] key;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < akd_pkg::NUM_KEYS; i++) begin
        level_q[i] <= akd_pkg::LEVEL_RESET[i];
      end
      tol_q      <= akd_pkg::TOLERANCE_RESET;
      debounce_q <= akd_pkg::DEBOUNCE_RESET;
      interval_q <= akd_pkg::INTERVAL_RESET;
    end else if (cfg_i.valid) begin
      for (int i = 0; i < akd_pkg::NUM_KEYS; i++) begin
        if (cfg_i.index == akd_pkg::CFG_IDX_W'(i)) begin
          level_q[i] <= cfg_i.data[akd_pkg::ADC_W-1:0];
        end
      end
      case (cfg_i.index)
        akd_pkg::REG_TOLERANCE:       tol_q      <= cfg_i.data[akd_pkg::TOL_W-1:0];
        akd_pkg::REG_DEBOUNCE_COUNT:  debounce_q <= cfg_i.data[akd_pkg::CNT_W-1:0];
        akd_pkg::REG_SAMPLE_INTERVAL: interval_q <= cfg_i.data[akd_pkg::IVL_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  // window test without signed maths: lvl - tol <= v  <=>  lvl <= v + tol
  always_comb begin
    v_ext   = {1'b0, sample_i.adc_value};
    tol_ext = {3'b000, tol_q};
    lvl_ext = '0;
    hit     = 1'b0;
    key     = akd_pkg::BAD_KEY;
    for (int i = 0; i < akd_pkg::NUM_KEYS; i++) begin
      lvl_ext = {1'b0, level_q[i]};
      if (!hit && (v_ext + tol_ext >= lvl_ext) && (v_ext <= lvl_ext + tol_ext)) begin
        hit = 1'b1;
        key = akd_pkg::KEY_W'(i + 1);
      end
    end
    if (sample_i.adc_value > akd_pkg::NO_KEY_THRESHOLD) begin
      key = akd_pkg::NO_KEY;
    end
  end

  assign sample_i.ready = !q_full_i;
  assign push_o         = sample_i.valid && !q_full_i;
  assign entry_o        = '{op: sample_i.op, key: key, now_ms: sample_i.now_ms};
  assign ctl_o          = '{repeat_need: debounce_q, sample_interval_ms: interval_q};

endmodule

`default_nettype wire

[design/akd_queue.sv]
// short queue of classified items between front and back end
`default_nettype none

module akd_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  akd_pkg::akd_entry_t entry_i,
  output logic                full_o,
  output logic                valid_o,
  output akd_pkg::akd_entry_t entry_o,
  input  wire                 pop_i
);

  akd_pkg::akd_entry_t              mem_q [akd_pkg::QDEPTH];
  logic [akd_pkg::QPTR_W-1:0]       wr_ptr_q;
  logic [akd_pkg::QPTR_W-1:0]       rd_ptr_q;
  logic [akd_pkg::QCNT_W-1:0]       count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: ;
      endcase
    end
  end

  assign full_o  = (count_q == akd_pkg::QCNT_W'(akd_pkg::QDEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= akd_pkg::QCNT_W'(akd_pkg::QDEPTH))
    else $error("queue count above depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");

endmodule

`default_nettype wire

[design/akd_back.sv]
// back end: interval gate, debounce state, flag and result register
`default_nettype none

module akd_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 q_valid_i,
  input  akd_pkg::akd_entry_t entry_i,
  input  akd_pkg::akd_ctl_t   ctl_i,
  output logic                pop_o,
  akd_result_if.source        result_o
);

  logic [akd_pkg::TIME_W-1:0] last_time_q, last_time_d;
  logic [akd_pkg::KEY_W-1:0]  prev_key_q, prev_key_d;
  logic [akd_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [akd_pkg::KEY_W-1:0]  stable_q, stable_d;
  logic                       avail_q, avail_d;

  logic                       out_valid_q;
  logic [akd_pkg::KEY_W-1:0]  out_key_q, out_key_d;
  logic                       out_taken_q, out_taken_d;
  logic                       out_pend_q;

  logic [akd_pkg::TIME_W-1:0] delta;

  assign pop_o = q_valid_i && (!out_valid_q || result_o.ready);
  assign delta = entry_i.now_ms - last_time_q;

  always_comb begin
    last_time_d = last_time_q;
    prev_key_d  = prev_key_q;
    cnt_d       = cnt_q;
    stable_d    = stable_q;
    avail_d     = avail_q;
    out_taken_d = 1'b0;
    out_key_d   = akd_pkg::NO_KEY;
    if (entry_i.op == akd_pkg::OP_READ) begin
      if (avail_q) begin
        avail_d   = 1'b0;
        out_key_d = stable_q;
      end
    end else begin
      if (delta >= {16'd0, ctl_i.sample_interval_ms}) begin
        out_taken_d = 1'b1;
        last_time_d = entry_i.now_ms;
        if (entry_i.key == prev_key_q) begin
          if (cnt_q != akd_pkg::CNT_MAX) begin
            cnt_d = cnt_q + 1'b1;
          end
          if (cnt_d >= ctl_i.repeat_need && entry_i.key != stable_q) begin
            stable_d = entry_i.key;
            if (entry_i.key != akd_pkg::NO_KEY) begin
              avail_d = 1'b1;
            end
          end
        end else begin
          prev_key_d = entry_i.key;
          cnt_d      = '0;
        end
      end
      out_key_d = stable_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q <= '0;
      prev_key_q  <= akd_pkg::NO_KEY;
      cnt_q       <= '0;
      stable_q    <= akd_pkg::NO_KEY;
      avail_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        last_time_q <= last_time_d;
        prev_key_q  <= prev_key_d;
        cnt_q       <= cnt_d;
        stable_q    <= stable_d;
        avail_q     <= avail_d;
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_key_q   <= out_key_d;
      out_taken_q <= out_taken_d;
      out_pend_q  <= avail_d;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.key_out      = out_key_q;
  assign result_o.sample_taken = out_taken_q;
  assign result_o.key_pending  = out_pend_q;

  a_stable_only_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop_o |=> $stable(stable_q) && $stable(avail_q))
    else $error("debounce state moved without an item");

  a_cnt_clear_on_new_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && prev_key_d != prev_key_q) |=> cnt_q == '0)
    else $error("stability counter not cleared on new key");

  a_flag_needs_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && !avail_q && avail_d) |-> stable_d != akd_pkg::NO_KEY)
    else $error("flag raised for no key");

endmodule

`default_nettype wire
